/* design/odo_pkg.sv */
// Shared types and constants for the differential drive odometry block.
// No dependencies; the top level and odo_cordic import this package.
package odo_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CORD,
        ST_MUL,
        ST_DONE
    } odo_state_t;

    typedef enum logic [1:0] {
        REG_DIST_PER_PULSE = 2'd0,
        REG_HEADING_GAIN   = 2'd1,
        REG_SAMPLE_RATE    = 2'd2
    } odo_reg_t;

    localparam logic signed [33:0] KINV_Q30 = 34'sd652032874;
    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [31:0] atan_lookup(input logic [4:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // clamp a wide signed value to the 32-bit signed range
    function automatic logic [31:0] sat32(input logic signed [PROD_W-1:0] v);
        logic [31:0] r;
        if (v > $signed({{(PROD_W-32){1'b0}}, 32'h7fff_ffff}))
        begin
            r = 32'h7fff_ffff;
        end
        else if (v < $signed({{(PROD_W-32){1'b1}}, 32'h8000_0000}))
        begin
            r = 32'h8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

/* design/odo_if.sv */
// Valid/ready channel interfaces for odometry samples and results.
// Depends on nothing; used by the top level.
interface odo_sample_if;
    logic        valid;
    logic        ready;
    logic [15:0] left_count;
    logic [15:0] right_count;
    modport source (output valid, left_count, right_count, input ready);
    modport sink   (input valid, left_count, right_count, output ready);
endinterface

interface odo_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] left_speed;
    logic [31:0] right_speed;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] heading;
    logic [31:0] travelled;
    modport source (output valid, left_speed, right_speed, pos_x, pos_y, heading, travelled,
                    input ready);
    modport sink   (input valid, left_speed, right_speed, pos_x, pos_y, heading, travelled,
                    output ready);
endinterface

/* design/differential_drive_odometry.sv */
// Top level of the differential drive odometry block: registers, sequencer, shared multiplier.
// Depends on odo_pkg, odo_if.sv and odo_cordic.
//
//  channel   dir  fields                                             transfer when
//  sample    in   left_count, right_count                            valid && ready
//  result    out  left_speed, right_speed, pos_x, pos_y, heading,    valid && ready
//                 travelled
//  config    in   cfg_index, cfg_data                                cfg_we
//
// After a sample transfer the sequencer starts the CORDIC, waits for its iterations, picks up
// its result, runs eight steps of the single 34x34 multiplier and loads the output register.
// Sample ready is high only while the sequencer is idle, so a new sample is not taken until
// the last one has reached the output register. A result sits there until taken; the next
// sample may enter meanwhile, and the sequencer stalls with its next result until the
// output register is free.
// Reset clears control, config, pose and distance registers; sample rate resets to one.
module differential_drive_odometry #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    odo_sample_if.sink  sample,
    odo_result_if.source result,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    import odo_pkg::*;

    odo_state_t state_reg, state_next;

    logic [2:0]  step_reg, step_next;
    logic [23:0] dpp_reg, gain_reg;
    logic [15:0] rate_reg;
    logic [15:0] prev_l_reg, prev_r_reg;
    logic signed [15:0] diff_l_reg, diff_r_reg;
    logic signed [31:0] dl_reg, dr_reg;
    logic [31:0] ls_reg, rs_reg;
    logic [31:0] x_reg, y_reg, ang_reg, dist_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic        out_valid_reg;
    logic [31:0] o_ls_reg, o_rs_reg, o_x_reg, o_y_reg, o_ang_reg, o_dist_reg;

    logic        accept, cord_start, cord_done, out_load, out_free;
    logic signed [33:0] cos_v, sin_v;
    logic signed [MUL_W-1:0] op_a, op_b;
    logic [15:0] inv_l, inv_r;
    logic signed [PROD_W-1:0] sum_w;
    logic signed [PROD_W-1:0] dist_add;

    assign accept   = sample.valid && sample.ready;
    assign out_free = !out_valid_reg || result.ready;
    assign inv_l    = ~sample.left_count;
    assign inv_r    = ~sample.right_count;

    odo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cord_start),
        .angle   (ang_reg),
        .done    (cord_done),
        .cos_val (cos_v),
        .sin_val (sin_v)
    );

    // operand select for the shared multiplier
    always_comb
    begin
        sum_w = PROD_W'(dl_reg) + PROD_W'(dr_reg);
        case (step_reg)
            3'd0:
            begin
                op_a = MUL_W'(diff_l_reg);
                op_b = $signed({10'b0, dpp_reg});
            end
            3'd1:
            begin
                op_a = MUL_W'(diff_r_reg);
                op_b = $signed({10'b0, dpp_reg});
            end
            3'd2:
            begin
                op_a = MUL_W'(dl_reg);
                op_b = $signed({18'b0, rate_reg});
            end
            3'd3:
            begin
                op_a = MUL_W'(dr_reg);
                op_b = $signed({18'b0, rate_reg});
            end
            3'd4:
            begin
                op_a = MUL_W'(dl_reg) - MUL_W'(dr_reg);
                op_b = $signed({10'b0, gain_reg});
            end
            3'd5:
            begin
                op_a = sum_w[MUL_W-1:0];
                op_b = cos_v;
            end
            default:
            begin
                op_a = sum_w[MUL_W-1:0];
                op_b = sin_v;
            end
        endcase
        dist_add = (PROD_W'($signed(ls_reg)) + PROD_W'($signed(rs_reg))) >>> 2;
    end

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        cord_start   = 1'b0;
        out_load     = 1'b0;
        sample.ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                sample.ready = 1'b1;
                if (sample.valid)
                begin
                    cord_start = 1'b1;
                    state_next = ST_CORD;
                end
            end
            ST_CORD:
            begin
                if (cord_done)
                begin
                    step_next  = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == 3'd7)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            dpp_reg       <= '0;
            gain_reg      <= '0;
            rate_reg      <= 16'd1;
            prev_l_reg    <= '0;
            prev_r_reg    <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            ang_reg       <= '0;
            dist_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DIST_PER_PULSE: dpp_reg  <= cfg_data;
                    REG_HEADING_GAIN:   gain_reg <= cfg_data;
                    REG_SAMPLE_RATE:    rate_reg <= cfg_data[15:0];
                    default:            ;
                endcase
            end
            if (accept)
            begin
                prev_l_reg <= inv_l;
                prev_r_reg <= inv_r;
            end
            if (state_reg == ST_MUL)
            begin
                case (step_reg)
                    3'd5: ang_reg  <= ang_reg + prod_reg[31:0];
                    3'd6: x_reg    <= sat32(PROD_W'($signed(x_reg)) + (prod_reg >>> 31));
                    3'd7:
                    begin
                        y_reg    <= sat32(PROD_W'($signed(y_reg)) + (prod_reg >>> 31));
                        dist_reg <= sat32(PROD_W'($signed(dist_reg)) + dist_add);
                    end
                    default: ;
                endcase
            end
        end
    end

    // datapath holding registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            diff_l_reg <= $signed(inv_l - prev_l_reg);
            diff_r_reg <= $signed(inv_r - prev_r_reg);
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= op_a * op_b;
            case (step_reg)
                3'd1: dl_reg <= prod_reg[39:8];
                3'd2: dr_reg <= prod_reg[39:8];
                3'd3: ls_reg <= sat32(prod_reg);
                3'd4: rs_reg <= sat32(prod_reg);
                default: ;
            endcase
        end
        if (out_load)
        begin
            o_ls_reg   <= ls_reg;
            o_rs_reg   <= rs_reg;
            o_x_reg    <= x_reg;
            o_y_reg    <= y_reg;
            o_ang_reg  <= ang_reg;
            o_dist_reg <= dist_reg;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.left_speed  = o_ls_reg;
    assign result.right_speed = o_rs_reg;
    assign result.pos_x       = o_x_reg;
    assign result.pos_y       = o_y_reg;
    assign result.heading     = o_ang_reg;
    assign result.travelled   = o_dist_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !sample.ready)
        else $error("sample taken while sequencer busy");

    a_cordic_in_cord: assert property (@(posedge clk) disable iff (!rst_n)
        cord_done |-> state_reg == ST_CORD)
        else $error("CORDIC finished outside its phase");

    a_load_frees: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("result overwritten before transfer");

    a_result_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(out_load))
        else $error("result valid without a finished sample");

endmodule

/* design/odo_cordic.sv */
// Iterative rotation-mode CORDIC giving Q3.30 cosine and sine of a binary angle.
// Depends on odo_pkg.
module odo_cordic #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [31:0]             angle,
    output logic                    done,
    output logic signed [33:0]      cos_val,
    output logic signed [33:0]      sin_val
);
    import odo_pkg::*;

    localparam int CW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic signed [33:0]   x_reg, x_next;
    logic signed [33:0]   y_reg, y_next;
    logic [31:0]          z_reg, z_next;
    logic signed [33:0]   xs, ys;
    logic [31:0]          atan_v;

    assign xs     = x_reg >>> cnt_reg;
    assign ys     = y_reg >>> cnt_reg;
    assign atan_v = atan_lookup(5'(cnt_reg));

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            y_next    = '0;
            // second and third quadrants: rotate from the negative axis
            if (angle[31] ^ angle[30])
            begin
                x_next = -KINV_Q30;
                z_next = {~angle[31], angle[30:0]};
            end
            else
            begin
                x_next = KINV_Q30;
                z_next = angle;
            end
        end
        else if (busy_reg)
        begin
            if (!z_reg[31])
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - atan_v;
            end
            else
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + atan_v;
            end
            if (cnt_reg == CW'(CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign done    = done_reg;
    assign cos_val = x_reg;
    assign sin_val = y_reg;

endmodule
